/* sv/h265rtp_pkg.sv */
// ============================================================================
// H.265 RTP packetizer package
// Shared widths, register codes, header constants and the result record.
// ============================================================================
package h265rtp_pkg;

    localparam int BYTE_W     = 8;
    localparam int SEQ_W      = 16;
    localparam int PLEN_W     = 13;
    localparam int TIME_W     = 32;
    localparam int LEN_IN_W   = 20;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W   = 64;
    localparam int S_LEN_LSB  = BYTE_W;
    localparam int S_TIME_LSB = BYTE_W + LEN_IN_W;

    localparam int M_DATA_W   = 72;
    localparam int M_USER_W   = 3;

    typedef enum logic [0:0] {
        REG_MAX_PAYLOAD = 1'b0,
        REG_SEQ_START   = 1'b1
    } cfg_reg_t;

    localparam logic [PLEN_W-1:0] MAXP_MIN   = 13'd16;
    localparam logic [PLEN_W-1:0] MAXP_MAX   = 13'd4096;
    localparam logic [PLEN_W-1:0] MAXP_RESET = 13'd1400;

    localparam logic [5:0]        FU_TYPE       = 6'd49;
    localparam logic [BYTE_W-1:0] PH_KEEP_MASK  = 8'h81;
    localparam logic [BYTE_W-1:0] NAL_TYPE_MASK = 8'h7E;
    localparam logic [BYTE_W-1:0] FU_S_BIT      = 8'h80;
    localparam logic [BYTE_W-1:0] FU_E_BIT      = 8'h40;
    localparam logic [PLEN_W-1:0] FU_HDR_BYTES  = 13'd3;

    // at most one record per input word: optional three header bytes, optional data byte
    typedef struct packed {
        logic              has_hdr;
        logic              has_data;
        logic [BYTE_W-1:0] hdr0;
        logic [BYTE_W-1:0] hdr1;
        logic [BYTE_W-1:0] hdr2;
        logic [BYTE_W-1:0] data;
        logic              d_start;
        logic              d_end;
        logic              marker;
        logic [PLEN_W-1:0] plen;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] ts;
    } rec_t;

endpackage

/* sv/h265rtp_emit.sv */
// ============================================================================
// H.265 RTP packetizer output stage
// Two-record queue; each record is expanded into one to four output words.
// ============================================================================
module h265rtp_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  h265rtp_pkg::rec_t             push_rec,
    input  logic                          push_valid,
    output logic                          push_ready,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_byte[7:0], seq_num[23:8], packet_length[36:24], time_out[68:37], zeros
    output logic [h265rtp_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // packet_start[0], marker_bit[1], run_end[2]
    output logic [h265rtp_pkg::M_USER_W-1:0] m_axis_tuser
);
    import h265rtp_pkg::*;

    rec_t        slot_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  ph_reg, ph_next;

    rec_t              head;
    logic [1:0]        last_ph;
    logic              is_last;
    logic              is_data_word;
    logic              word_start;
    logic [BYTE_W-1:0] word_byte;
    logic              push, pop, beat;

    assign head         = slot_reg[rd_ptr_reg];
    assign last_ph      = head.has_hdr ? (head.has_data ? 2'd3 : 2'd2) : 2'd0;
    assign is_last      = (ph_reg == last_ph);
    assign is_data_word = !head.has_hdr || (ph_reg == 2'd3);
    assign word_start   = head.has_hdr ? (ph_reg == 2'd0) : head.d_start;

    always_comb
    begin
        case (ph_reg)
            2'd0:    word_byte = head.has_hdr ? head.hdr0 : head.data;
            2'd1:    word_byte = head.hdr1;
            2'd2:    word_byte = head.hdr2;
            default: word_byte = head.data;
        endcase
    end

    assign push_ready    = (count_reg != 2'd2);
    assign push          = push_valid && push_ready;
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign beat          = m_axis_tvalid && m_axis_tready;
    assign pop           = beat && is_last;

    assign m_axis_tdata = {3'b000, head.ts, head.plen, head.seq, word_byte};
    assign m_axis_tlast = is_data_word && head.d_end;
    assign m_axis_tuser = {is_last, head.marker, word_start};

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        ph_next     = ph_reg;
        if (beat)
        begin
            ph_next = is_last ? 2'd0 : ph_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            ph_reg     <= 2'd0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            ph_reg     <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("record queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> (count_reg == 2'd2))
        else $error("record queue lost or gained an entry while full");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd0) |-> (ph_reg <= last_ph))
        else $error("word index beyond record");

    a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (ph_reg == 2'd0))
        else $error("word index not cleared with empty queue");
`endif

endmodule

/* sv/h265_rtp_packetizer.sv */
// ============================================================================
// H.265 RTP packetizer
// Single-NAL-unit packets and fragmentation units (type 49) from a NAL
// byte stream.
//
//  channel   dir  handshake             content
//  s_axis    in   tvalid/tready         NAL byte, length, timestamp; tuser = first
//  m_axis    out  tvalid/tready         payload byte, seq, length, time; tlast = end
//  cfg       in   cfg_valid/cfg_ready   register index, write data
//
// One input word per cycle while each yields at most one output word and the
// receiver keeps m_axis_tready high. The second byte of a fragmented unit
// yields three header words and a word that opens a later fragment yields
// four; the two-record output queue then sets the input rate. Output words
// come from records that are registered in that queue. Reset clears all
// control state, max_payload returns to 1400, sequence counter to 0. Output
// stalls back up into s_axis_tready only when both queue records are held.
// ============================================================================
module h265_rtp_packetizer
#(
    parameter int NAL_LEN_BITS = 20
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // nal_byte[7:0], nal_length[27:8], frame_time[59:28], zeros
    input  logic [h265rtp_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // nal_first[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_byte[7:0], seq_num[23:8], packet_length[36:24], time_out[68:37], zeros
    output logic [h265rtp_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // packet_start[0], marker_bit[1], run_end[2]
    output logic [h265rtp_pkg::M_USER_W-1:0]    m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  h265rtp_pkg::cfg_reg_t               cfg_index,
    input  logic [h265rtp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import h265rtp_pkg::*;

    localparam int LB = (NAL_LEN_BITS < LEN_IN_W) ? NAL_LEN_BITS : LEN_IN_W;
    localparam int CW = (LB > PLEN_W) ? LB : PLEN_W;

    logic [PLEN_W-1:0] maxp_reg, maxp_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [LB-1:0]     npos_reg, npos_next;
    logic [PLEN_W-1:0] ppos_reg, ppos_next;
    logic              frag_reg, frag_next;
    logic [BYTE_W-1:0] h0_reg, h0_next;
    logic [BYTE_W-1:0] h1_reg, h1_next;
    logic [LB-1:0]     ulen_reg, ulen_next;
    logic [TIME_W-1:0] utime_reg, utime_next;
    logic [PLEN_W-1:0] umax_reg, umax_next;
    logic [PLEN_W-1:0] flen_reg, flen_next;
    logic              flast_reg, flast_next;

    logic [BYTE_W-1:0]   in_byte;
    logic                in_first;
    logic [LEN_IN_W-1:0] in_len;
    logic [TIME_W-1:0]   in_time;
    logic [LB-1:0]       len_eff;
    logic [PLEN_W-1:0]   m_sat;

    logic              accept, active;
    logic              cur_frag;
    logic [LB-1:0]     cur_pos, cur_ulen;
    logic [PLEN_W-1:0] cur_ppos, cur_umax;
    logic [TIME_W-1:0] cur_time;

    logic [CW-1:0]     dlen_c, pos_c, rem_c, cand_c, umax_c;
    logic [PLEN_W-1:0] ppos_inc, plen_c;
    logic              first_frag;
    logic              pkt_end;

    rec_t rec;
    logic push_valid, push_ready;

    assign in_byte  = s_axis_tdata[BYTE_W-1:0];
    assign in_first = s_axis_tuser;
    assign in_len   = s_axis_tdata[S_LEN_LSB +: LEN_IN_W];
    assign in_time  = s_axis_tdata[S_TIME_LSB +: TIME_W];

    assign len_eff = (in_len[LB-1:0] == '0) ? LB'(1) : in_len[LB-1:0];
    assign m_sat   = (maxp_reg < MAXP_MIN) ? MAXP_MIN :
                     (maxp_reg > MAXP_MAX) ? MAXP_MAX : maxp_reg;

    assign s_axis_tready = push_ready;
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign active        = in_first || (npos_reg < ulen_reg);

    assign cur_ulen = in_first ? len_eff : ulen_reg;
    assign cur_pos  = in_first ? '0 : npos_reg;
    assign cur_ppos = in_first ? '0 : ppos_reg;
    assign cur_umax = in_first ? m_sat : umax_reg;
    assign cur_time = in_first ? in_time : utime_reg;
    assign cur_frag = in_first ? (CW'(len_eff) > CW'(m_sat)) : frag_reg;

    assign dlen_c   = CW'(cur_ulen) - CW'(2);
    assign pos_c    = CW'(cur_pos);
    assign umax_c   = CW'(cur_umax);
    assign cand_c   = dlen_c - CW'(1);
    assign rem_c    = dlen_c - (pos_c - CW'(2));
    assign ppos_inc = ((cur_ppos == '0) ? FU_HDR_BYTES : cur_ppos) + PLEN_W'(1);

    always_comb
    begin
        maxp_next  = maxp_reg;
        seq_next   = seq_reg;
        npos_next  = npos_reg;
        ppos_next  = ppos_reg;
        frag_next  = frag_reg;
        h0_next    = h0_reg;
        h1_next    = h1_reg;
        ulen_next  = ulen_reg;
        utime_next = utime_reg;
        umax_next  = umax_reg;
        flen_next  = flen_reg;
        flast_next = flast_reg;
        first_frag = 1'b0;
        plen_c     = '0;
        pkt_end    = 1'b0;
        push_valid = 1'b0;

        rec.has_hdr  = 1'b0;
        rec.has_data = 1'b0;
        rec.data     = in_byte;
        rec.d_start  = 1'b0;
        rec.d_end    = 1'b0;
        rec.marker   = 1'b0;
        rec.plen     = '0;
        rec.seq      = seq_reg;
        rec.ts       = cur_time;

        if (accept && active)
        begin
            npos_next  = cur_pos + LB'(1);
            ulen_next  = cur_ulen;
            utime_next = cur_time;
            umax_next  = cur_umax;
            frag_next  = cur_frag;
            ppos_next  = cur_ppos;
            if (in_first)
            begin
                flast_next = 1'b0;
            end

            if (!cur_frag)
            begin
                pkt_end      = (cur_pos + LB'(1) == cur_ulen);
                push_valid   = 1'b1;
                rec.has_data = 1'b1;
                rec.d_start  = (cur_pos == '0);
                rec.d_end    = pkt_end;
                rec.marker   = 1'b1;
                rec.plen     = PLEN_W'(CW'(cur_ulen));
                if (pkt_end)
                begin
                    seq_next = seq_reg + SEQ_W'(1);
                end
            end
            else if (cur_pos == '0)
            begin
                h0_next = in_byte;
            end
            else if (cur_pos == LB'(1))
            begin
                h1_next    = in_byte;
                flen_next  = (cand_c < umax_c) ? PLEN_W'(cand_c) : cur_umax;
                flast_next = 1'b0;
                ppos_next  = FU_HDR_BYTES;
                first_frag = 1'b1;
                push_valid = 1'b1;
                rec.has_hdr = 1'b1;
                rec.marker  = 1'b0;
                rec.plen    = flen_next + FU_HDR_BYTES;
            end
            else
            begin
                if (cur_ppos == '0)
                begin
                    flen_next   = (rem_c < umax_c) ? PLEN_W'(rem_c) : cur_umax;
                    flast_next  = (rem_c <= umax_c);
                    rec.has_hdr = 1'b1;
                end
                plen_c       = flen_next + FU_HDR_BYTES;
                pkt_end      = (ppos_inc == plen_c);
                ppos_next    = pkt_end ? '0 : ppos_inc;
                push_valid   = 1'b1;
                rec.has_data = 1'b1;
                rec.d_end    = pkt_end;
                rec.marker   = flast_next;
                rec.plen     = plen_c;
                if (pkt_end)
                begin
                    seq_next = seq_reg + SEQ_W'(1);
                end
            end
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD: maxp_next = cfg_data[PLEN_W-1:0];
                REG_SEQ_START:   seq_next  = cfg_data;
                default:         maxp_next = maxp_reg;
            endcase
        end

        // FU header bytes
        rec.hdr0 = (h0_reg & PH_KEEP_MASK) | {1'b0, FU_TYPE, 1'b0};
        rec.hdr1 = (cur_pos == LB'(1)) ? in_byte : h1_reg;
        rec.hdr2 = ((h0_reg & NAL_TYPE_MASK) >> 1)
                 | (first_frag ? FU_S_BIT : '0)
                 | (flast_next ? FU_E_BIT : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxp_reg  <= MAXP_RESET;
            seq_reg   <= '0;
            npos_reg  <= '0;
            ppos_reg  <= '0;
            frag_reg  <= 1'b0;
            h0_reg    <= '0;
            h1_reg    <= '0;
            ulen_reg  <= '0;
            utime_reg <= '0;
            umax_reg  <= MAXP_RESET;
            flen_reg  <= '0;
            flast_reg <= 1'b0;
        end
        else
        begin
            maxp_reg  <= maxp_next;
            seq_reg   <= seq_next;
            npos_reg  <= npos_next;
            ppos_reg  <= ppos_next;
            frag_reg  <= frag_next;
            h0_reg    <= h0_next;
            h1_reg    <= h1_next;
            ulen_reg  <= ulen_next;
            utime_reg <= utime_next;
            umax_reg  <= umax_next;
            flen_reg  <= flen_next;
            flast_reg <= flast_next;
        end
    end

    h265rtp_emit u_emit
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_rec      (rec),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* dv/h265_rtp_packetizer_test.sv */
// ============================================================================
// H.265 RTP packetizer testbench
// Feeds NAL units as byte streams and predicts every payload word the block
// sends: single-unit packets, fragmentation units with their payload and FU
// headers, sequence wrap, dropped units and register writes between bursts.
// A short directed table comes first, then random units under three idle
// mixes, including a long receiver stall.
// ============================================================================
module h265_rtp_packetizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import h265rtp_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned LONG_HOLD    = 400;

    localparam int unsigned PAYLOAD_FLOOR    = 16;
    localparam int unsigned PAYLOAD_CEIL     = 4096;
    localparam int unsigned PAYLOAD_AT_RESET = 1400;
    localparam logic [5:0]  FU_PAYLOAD_TYPE  = 6'd49;
    localparam logic [7:0]  KEEP_FZ_LAYER    = 8'h81;
    localparam logic [7:0]  TYPE_FIELD       = 8'h7E;
    localparam logic [7:0]  START_FLAG       = 8'h80;
    localparam logic [7:0]  END_FLAG         = 8'h40;

    typedef struct {
        logic [7:0]  pl_byte;
        logic        opens;
        logic        closes;
        logic        marker;
        logic [15:0] seq;
        logic [12:0] plen;
        logic [31:0] ts;
        logic        run_end;
    } payload_byte_t;

    typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        first;
        logic [7:0]  nb;
        logic [19:0] len;
        logic [31:0] ts;
        cfg_reg_t    reg_sel;
        logic [15:0] val;
        bit          chk;
        logic [7:0]  e_byte;
        logic [15:0] e_seq;
        logic [12:0] e_plen;
        logic [2:0]  e_flags;   // {start, end, marker}
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index = REG_MAX_PAYLOAD;
    logic [15:0] cfg_data = '0;

    // predictor state
    logic [12:0] lim_reg = 13'(PAYLOAD_AT_RESET);
    logic [15:0] seq_ctr = '0;
    int unsigned nal_pos = 0;
    int unsigned pkt_pos = 0;
    bit          in_frag = 1'b0;
    logic [7:0]  hdr0 = '0;
    logic [7:0]  hdr1 = '0;
    int unsigned unit_len = 0;
    logic [31:0] unit_ts = '0;
    int unsigned unit_lim = PAYLOAD_AT_RESET;
    int unsigned frag_bytes = 0;
    bit          frag_final = 1'b0;

    payload_byte_t expected_payload[$];
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;

    bit          typed_on = 1'b0;
    stim_row_t   typed_row;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    h265_rtp_packetizer #(.NAL_LEN_BITS(20)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic emit(input logic [7:0] b, input bit opens, input bit closes,
                        input bit marker, input int unsigned plen);
        payload_byte_t e;
        e.pl_byte = b;
        e.opens   = opens;
        e.closes  = closes;
        e.marker  = marker;
        e.seq     = seq_ctr;
        e.plen    = plen[12:0];
        e.ts      = unit_ts;
        e.run_end = 1'b0;
        expected_payload.push_back(e);
    endtask

    task automatic emit_fu_headers(input bit opening);
        logic [7:0] fu;
        fu = (hdr0 & TYPE_FIELD) >> 1;
        if (opening)
            fu = fu | START_FLAG;
        if (frag_final)
            fu = fu | END_FLAG;
        emit((hdr0 & KEEP_FZ_LAYER) | {1'b0, FU_PAYLOAD_TYPE, 1'b0}, 1'b1, 1'b0,
             frag_final, frag_bytes + 3);
        emit(hdr1, 1'b0, 1'b0, frag_final, frag_bytes + 3);
        emit(fu, 1'b0, 1'b0, frag_final, frag_bytes + 3);
        pkt_pos = 3;
    endtask

    task automatic packetize_word(input logic [7:0] b, input logic first,
                                  input logic [19:0] len_in, input logic [31:0] ts);
        int unsigned base;
        int unsigned pos;
        int unsigned dlen;
        int unsigned rem;
        bit          closes;
        base = expected_payload.size();
        if (first)
        begin
            unit_lim = lim_reg;
            if (unit_lim < PAYLOAD_FLOOR)
                unit_lim = PAYLOAD_FLOOR;
            if (unit_lim > PAYLOAD_CEIL)
                unit_lim = PAYLOAD_CEIL;
            unit_len   = (len_in == 0) ? 1 : len_in;
            unit_ts    = ts;
            in_frag    = unit_len > unit_lim;
            nal_pos    = 0;
            pkt_pos    = 0;
            frag_final = 1'b0;
        end
        else if (nal_pos >= unit_len)
            return;
        pos = nal_pos;
        nal_pos++;
        if (!in_frag)
        begin
            closes = (pos + 1 == unit_len);
            emit(b, pos == 0, closes, 1'b1, unit_len);
            pkt_pos = closes ? 0 : pkt_pos + 1;
            if (closes)
                seq_ctr++;
        end
        else
        begin
            dlen = unit_len - 2;
            if (pos == 0)
                hdr0 = b;
            else if (pos == 1)
            begin
                hdr1       = b;
                frag_bytes = (dlen - 1 < unit_lim) ? dlen - 1 : unit_lim;
                frag_final = 1'b0;
                emit_fu_headers(1'b1);
            end
            else
            begin
                if (pkt_pos == 0)
                begin
                    rem        = dlen - (pos - 2);
                    frag_bytes = (rem < unit_lim) ? rem : unit_lim;
                    frag_final = rem <= unit_lim;
                    emit_fu_headers(1'b0);
                end
                pkt_pos++;
                closes = (pkt_pos == frag_bytes + 3);
                emit(b, 1'b0, closes, frag_final, frag_bytes + 3);
                if (closes)
                begin
                    seq_ctr++;
                    pkt_pos = 0;
                end
            end
        end
        if (expected_payload.size() > base)
        begin
            expected_payload[expected_payload.size() - 1].run_end = 1'b1;
            if (typed_on)
            begin
                compare_field("table out_byte", typed_row.e_byte,
                              expected_payload[base].pl_byte);
                compare_field("table seq_num", typed_row.e_seq, expected_payload[base].seq);
                compare_field("table packet_length", typed_row.e_plen,
                              expected_payload[base].plen);
                compare_field("table flags", typed_row.e_flags,
                              {expected_payload[base].opens, expected_payload[base].closes,
                               expected_payload[base].marker});
            end
        end
    endtask

    task automatic check_payload();
        payload_byte_t e;
        if (expected_payload.size() == 0)
        begin
            $display("%0t: payload word expected none actual %h", $time, m_axis_tdata);
            mismatches++;
        end
        else
        begin
            e = expected_payload.pop_front();
            compare_field("out_byte", e.pl_byte, m_axis_tdata[7:0]);
            compare_field("seq_num", e.seq, m_axis_tdata[23:8]);
            compare_field("packet_length", e.plen, m_axis_tdata[36:24]);
            compare_field("time_out", e.ts, m_axis_tdata[68:37]);
            compare_field("packet_start", e.opens, m_axis_tuser[0]);
            compare_field("packet_end", e.closes, m_axis_tlast);
            compare_field("marker_bit", e.marker, m_axis_tuser[1]);
            compare_field("run_end", e.run_end, m_axis_tuser[2]);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_PAYLOAD)
                    lim_reg = cfg_data[12:0];
                else
                    seq_ctr = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                packetize_word(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[27:8],
                               s_axis_tdata[59:28]);
            if (m_axis_tvalid && m_axis_tready)
                check_payload();
        end
    end

    // receiver: random stalls, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served   <= hold_asked;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_word(input logic first, input logic [7:0] b,
                             input logic [19:0] len, input logic [31:0] ts);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= first;
        s_axis_tdata  <= {4'h0, ts, len, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_payload.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t sel, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_nal(input logic [19:0] len_field, input int unsigned nbytes);
        for (int unsigned i = 0; i < nbytes; i++)
            send_word(i == 0, 8'($urandom), (i == 0) ? len_field : 20'($urandom),
                      $urandom);
    endtask

    // mostly well-formed units; some cut short, some short lengths, some noise
    task automatic run_phase(input int unsigned budget, input int unsigned span,
                             input int unsigned lim_len);
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        int unsigned n;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_word(1'b0, 8'($urandom), 20'($urandom), $urandom);
            else if (r < 14)
            begin
                len = $urandom_range(0, 1) ? $urandom_range(3, 20'hFFFFF)
                                           : $urandom_range(3, span);
                n = $urandom_range(1, span);
                if (n >= len)
                    n = len - 1;
                send_nal(20'(len), n);
                sent += n;
            end
            else if (r < 20)
            begin
                len = $urandom_range(0, 3);
                n = (len == 0) ? 1 : len;
                send_nal(20'(len), n);
                sent += n;
            end
            else
            begin
                if (r < 30 && lim_len != 0)
                    len = lim_len - 1 + $urandom_range(0, 2);
                else
                    len = $urandom_range(3, span);
                send_nal(20'(len), len);
                sent += len;
            end
        end
    endtask

    function automatic stim_row_t word_row(input logic first, input logic [7:0] b,
                                           input logic [19:0] len, input logic [31:0] ts);
        stim_row_t r;
        r.kind    = ROW_WORD;
        r.first   = first;
        r.nb      = b;
        r.len     = len;
        r.ts      = ts;
        r.reg_sel = REG_MAX_PAYLOAD;
        r.val     = '0;
        r.chk     = 1'b0;
        r.e_byte  = '0;
        r.e_seq   = '0;
        r.e_plen  = '0;
        r.e_flags = '0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_reg_t sel, input logic [15:0] val);
        stim_row_t r;
        r         = word_row(1'b0, 8'h00, 20'h0, 32'h0);
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.val     = val;
        return r;
    endfunction

    function automatic stim_row_t checked_row(input logic first, input logic [7:0] b,
                                              input logic [19:0] len, input logic [31:0] ts,
                                              input logic [7:0] eb, input logic [15:0] es,
                                              input logic [12:0] ep, input logic [2:0] ef);
        stim_row_t r;
        r         = word_row(first, b, len, ts);
        r.chk     = 1'b1;
        r.e_byte  = eb;
        r.e_seq   = es;
        r.e_plen  = ep;
        r.e_flags = ef;
        return r;
    endfunction

    initial
    begin
        stim_row_t   dir_rows [30];
        int unsigned mid_lim;

        // orphan word; 3-byte, 1-byte (length 0) and 2-byte units; a huge unit
        // dropped after its first data byte; a unit one byte over the limit,
        // with register writes between its data bytes
        dir_rows = '{
            word_row   (1'b0, 8'hFF, 20'hFFFFF, 32'h0),
            checked_row(1'b1, 8'h40, 20'd3, 32'hFFFF_FFFF, 8'h40, 16'd0, 13'd3, 3'b101),
            word_row   (1'b0, 8'h01, 20'h0, 32'h0),
            checked_row(1'b0, 8'hAA, 20'hFFFFF, 32'h0, 8'hAA, 16'd0, 13'd3, 3'b011),
            checked_row(1'b1, 8'h00, 20'd0, 32'h0, 8'h00, 16'd1, 13'd1, 3'b111),
            checked_row(1'b1, 8'h26, 20'd2, 32'h1234_5678, 8'h26, 16'd2, 13'd2, 3'b101),
            word_row   (1'b0, 8'h01, 20'h0, 32'h0),
            word_row   (1'b1, 8'hFF, 20'hFFFFF, 32'hA5A5_5A5A),
            checked_row(1'b0, 8'h01, 20'h0, 32'h0, 8'hE3, 16'd3, 13'd1403, 3'b100),
            word_row   (1'b0, 8'h55, 20'h0, 32'h0),
            cfg_row    (REG_MAX_PAYLOAD, 16'h0000),
            word_row   (1'b1, 8'h4E, 20'd17, 32'h0BAD_F00D),
            checked_row(1'b0, 8'h01, 20'h0, 32'h0, 8'h62, 16'd3, 13'd17, 3'b100),
            word_row   (1'b0, 8'h00, 20'h0, 32'h0),
            word_row   (1'b0, 8'hFF, 20'h0, 32'h0),
            word_row   (1'b0, 8'h80, 20'h0, 32'h0),
            word_row   (1'b0, 8'h7F, 20'h0, 32'h0),
            word_row   (1'b0, 8'h01, 20'h0, 32'h0),
            word_row   (1'b0, 8'hFE, 20'h0, 32'h0),
            word_row   (1'b0, 8'h10, 20'h0, 32'h0),
            cfg_row    (REG_SEQ_START, 16'hFFFF),
            cfg_row    (REG_MAX_PAYLOAD, 16'hFFFF),
            word_row   (1'b0, 8'h20, 20'h0, 32'h0),
            word_row   (1'b0, 8'h40, 20'h0, 32'h0),
            word_row   (1'b0, 8'h08, 20'h0, 32'h0),
            word_row   (1'b0, 8'h04, 20'h0, 32'h0),
            word_row   (1'b0, 8'h02, 20'h0, 32'h0),
            word_row   (1'b0, 8'hC3, 20'h0, 32'h0),
            word_row   (1'b0, 8'h3C, 20'h0, 32'h0),
            checked_row(1'b0, 8'h99, 20'h0, 32'h0, 8'h62, 16'd0, 13'd4, 3'b101)
        };

        tx_idle_pct = 17;
        rx_idle_pct <= 87;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
            begin
                drain();
                cfg_write(dir_rows[k].reg_sel, dir_rows[k].val);
            end
            else
            begin
                typed_row = dir_rows[k];
                typed_on  = dir_rows[k].chk;
                send_word(dir_rows[k].first, dir_rows[k].nb, dir_rows[k].len, dir_rows[k].ts);
                typed_on  = 1'b0;
            end
        end

        drain();
        cfg_write(REG_MAX_PAYLOAD, 16'd16);
        cfg_write(REG_SEQ_START, 16'($urandom));
        run_phase(60, 60, 16);

        drain();
        tx_idle_pct = 87;
        rx_idle_pct <= 17;
        mid_lim = $urandom_range(17, 48);
        cfg_write(REG_MAX_PAYLOAD, 16'(mid_lim));
        cfg_write(REG_SEQ_START, 16'hFFF0);
        run_phase(70, 2 * mid_lim + 8, mid_lim);

        // no idling; receiver blocked for a long stretch at the start
        drain();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        cfg_write(REG_MAX_PAYLOAD, 16'h1FFF);
        cfg_write(REG_SEQ_START, 16'h0000);
        hold_asked <= hold_asked + 1;
        run_phase(30, 40, 0);
        drain();
        cfg_write(REG_MAX_PAYLOAD, 16'd4096);
        run_phase(25, 40, 0);

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
sv/h265rtp_pkg.sv
sv/h265rtp_emit.sv
sv/h265_rtp_packetizer.sv
dv/h265_rtp_packetizer_test.sv
